FILE: src/pal_pkg.sv
// Package: shared types, codes and defaults of the polyline arc-length interpolator.
`timescale 1ns / 1ps
package pal_pkg;

    // Default configuration of the block.
    localparam int MAX_POINTS_DEF      = 64;
    localparam int COORD_BITS_DEF      = 32;
    localparam int PARAM_FRAC_BITS_DEF = 16;

    // Fixed field widths.
    localparam int LEN_BITS  = 40;
    localparam int TOL_BITS  = 8;
    localparam int KIND_BITS = 2;

    // Command codes of an input item.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Result kinds.
    localparam logic [KIND_BITS-1:0] KIND_LEN  = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_POS  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_NONE = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LD_CHK,
        S_LD_SQ0,
        S_LD_SQ1,
        S_LD_SQ2,
        S_LD_SQ3,
        S_LD_RT,
        S_LD_RW,
        S_LD_COMMIT,
        S_NRM_INIT,
        S_NRM_RD,
        S_NRM_DIV,
        S_NRM_WAIT,
        S_NRM_END,
        S_Q_CHK,
        S_Q_ERD,
        S_Q_EOUT,
        S_Q_SRD,
        S_Q_SCMP,
        S_Q_P0RD,
        S_Q_P0,
        S_Q_P1,
        S_Q_DIVW,
        S_Q_LX,
        S_Q_LY,
        S_Q_LZ,
        S_Q_OUT
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_SQX,
        MUL_SQY,
        MUL_SQZ,
        MUL_LX,
        MUL_LY,
        MUL_LZ
    } t_mul_op;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef enum logic [1:0] {
        PW_NONE,
        PW_ZERO,
        PW_DIV,
        PW_ONE
    } t_prm_wr;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_SEG,
        RD_SEG1
    } t_rd_sel;

    // Controller to datapath.
    typedef struct packed {
        logic                 accept;
        logic                 commit;
        logic                 first;
        t_mul_op              mul_op;
        t_acc_op              acc_op;
        logic                 sqrt_go;
        logic                 close;
        t_prm_wr              prm_wr;
        logic                 idx_one;
        logic                 idx_inc;
        t_rd_sel              rd_sel;
        logic                 div_go;
        logic                 div_qry;
        logic                 lam_wr;
        logic                 set_end;
        logic                 hit_wr;
        logic                 p0_wr;
        logic                 p1_wr;
        logic                 emit;
        logic [KIND_BITS-1:0] kind;
        logic                 pos_lerp;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic last;
        logic closed;
        logic full;
        logic cnt_zero;
        logic cnt_one;
        logic cnt_gt1;
        logic cnt_gt2;
        logic snap_first;
        logic snap_last;
        logic idx_pen;
        logic hit;
        logic sqrt_done;
        logic div_done;
    } t_status;

endpackage

FILE: src/pal_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read one entry each cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/pal_sqrt.sv
// Bit-serial integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module pal_sqrt #(
    parameter int RW = 34
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [2*RW-1:0] i_rad,
    output logic            o_done,
    output logic [RW-1:0]   o_root
);
    localparam int CNTW = $clog2(RW + 1);

    logic [2*RW-1:0] r_rad;
    logic [RW+2:0]   r_rem;
    logic [RW-1:0]   r_root;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;

    logic [RW+2:0] n_sh;
    logic [RW+2:0] n_trial;
    logic          n_ge;

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
        n_sh    = {r_rem[RW:0], r_rad[2*RW-1 -: 2]};
        n_trial = {1'b0, r_root, 2'b01};
        n_ge    = n_sh >= n_trial;
    end

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(RW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and root registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[2*RW-3:0], 2'b00};
            r_rem  <= n_ge ? n_sh - n_trial : n_sh;
            r_root <= {r_root[RW-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

FILE: src/pal_div.sv
// Restoring divider for fractions: quotient of QW bits with num < 2*den.
`timescale 1ns / 1ps
module pal_div #(
    parameter int DW = 40,
    parameter int QW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [QW-1:0] o_quo
);
    localparam int CNTW = $clog2(QW + 1);

    logic [DW:0]     r_rem;
    logic [DW-1:0]   r_den;
    logic [QW-1:0]   r_quo;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;

    logic        n_ge;
    logic [DW:0] n_diff;

    // Compare and subtract one quotient bit.
    always_comb begin
        n_ge   = r_rem >= {1'b0, r_den};
        n_diff = n_ge ? r_rem - {1'b0, r_den} : r_rem;
    end

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= {n_diff[DW-1:0], 1'b0};
            r_quo <= {r_quo[QW-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

FILE: src/pal_ctrl.sv
// Controller state machine: sequences loads, normalization and queries.
`timescale 1ns / 1ps
module pal_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            i_func,
    input  pal_pkg::t_status i_st,
    output pal_pkg::t_cmd   o_cmd,
    output logic            busy
);
    pal_pkg::t_state r_state;
    pal_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pal_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.mul_op  = pal_pkg::MUL_NONE;
        o_cmd.acc_op  = pal_pkg::ACC_NONE;
        o_cmd.prm_wr  = pal_pkg::PW_NONE;
        o_cmd.rd_sel  = pal_pkg::RD_IDX;
        o_cmd.kind    = pal_pkg::KIND_NONE;
        busy          = 1'b1;
        case (r_state)
            pal_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.accept = 1'b1;
                    n_state = (i_func == pal_pkg::FUNC_QUERY) ? pal_pkg::S_Q_CHK
                                                              : pal_pkg::S_LD_CHK;
                end
            end
            // Load path.
            pal_pkg::S_LD_CHK: begin
                if (i_st.full) begin
                    n_state = i_st.last ? pal_pkg::S_NRM_INIT : pal_pkg::S_IDLE;
                end else if (i_st.cnt_zero) begin
                    n_state = pal_pkg::S_LD_COMMIT;
                end else begin
                    n_state = pal_pkg::S_LD_SQ0;
                end
            end
            pal_pkg::S_LD_SQ0: begin
                o_cmd.mul_op = pal_pkg::MUL_SQX;
                n_state = pal_pkg::S_LD_SQ1;
            end
            pal_pkg::S_LD_SQ1: begin
                o_cmd.mul_op = pal_pkg::MUL_SQY;
                o_cmd.acc_op = pal_pkg::ACC_LOAD;
                n_state = pal_pkg::S_LD_SQ2;
            end
            pal_pkg::S_LD_SQ2: begin
                o_cmd.mul_op = pal_pkg::MUL_SQZ;
                o_cmd.acc_op = pal_pkg::ACC_ADD;
                n_state = pal_pkg::S_LD_SQ3;
            end
            pal_pkg::S_LD_SQ3: begin
                o_cmd.acc_op = pal_pkg::ACC_ADD;
                n_state = pal_pkg::S_LD_RT;
            end
            pal_pkg::S_LD_RT: begin
                o_cmd.sqrt_go = 1'b1;
                n_state = pal_pkg::S_LD_RW;
            end
            pal_pkg::S_LD_RW: begin
                if (i_st.sqrt_done) begin
                    n_state = pal_pkg::S_LD_COMMIT;
                end
            end
            pal_pkg::S_LD_COMMIT: begin
                o_cmd.commit = 1'b1;
                o_cmd.first  = i_st.cnt_zero;
                n_state = i_st.last ? pal_pkg::S_NRM_INIT : pal_pkg::S_IDLE;
            end
            // Normalization of the cumulative distances.
            pal_pkg::S_NRM_INIT: begin
                o_cmd.close   = 1'b1;
                o_cmd.prm_wr  = pal_pkg::PW_ZERO;
                o_cmd.idx_one = 1'b1;
                n_state = i_st.cnt_gt2 ? pal_pkg::S_NRM_RD : pal_pkg::S_NRM_END;
            end
            pal_pkg::S_NRM_RD: begin
                o_cmd.rd_sel = pal_pkg::RD_IDX;
                n_state = pal_pkg::S_NRM_DIV;
            end
            pal_pkg::S_NRM_DIV: begin
                o_cmd.div_go = 1'b1;
                n_state = pal_pkg::S_NRM_WAIT;
            end
            pal_pkg::S_NRM_WAIT: begin
                if (i_st.div_done) begin
                    o_cmd.prm_wr  = pal_pkg::PW_DIV;
                    o_cmd.idx_inc = 1'b1;
                    n_state = i_st.idx_pen ? pal_pkg::S_NRM_END : pal_pkg::S_NRM_RD;
                end
            end
            pal_pkg::S_NRM_END: begin
                if (i_st.cnt_gt1) begin
                    o_cmd.prm_wr = pal_pkg::PW_ONE;
                end
                o_cmd.emit = 1'b1;
                o_cmd.kind = pal_pkg::KIND_LEN;
                n_state = pal_pkg::S_IDLE;
            end
            // Query path.
            pal_pkg::S_Q_CHK: begin
                if (!i_st.closed || i_st.cnt_zero) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = pal_pkg::KIND_NONE;
                    n_state = pal_pkg::S_IDLE;
                end else if (i_st.cnt_one || i_st.snap_first || i_st.snap_last) begin
                    o_cmd.set_end = 1'b1;
                    n_state = pal_pkg::S_Q_ERD;
                end else begin
                    o_cmd.idx_one = 1'b1;
                    n_state = pal_pkg::S_Q_SRD;
                end
            end
            pal_pkg::S_Q_ERD: begin
                o_cmd.rd_sel = pal_pkg::RD_SEG;
                n_state = pal_pkg::S_Q_EOUT;
            end
            pal_pkg::S_Q_EOUT: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = pal_pkg::KIND_POS;
                n_state = pal_pkg::S_IDLE;
            end
            pal_pkg::S_Q_SRD: begin
                o_cmd.rd_sel = pal_pkg::RD_IDX;
                n_state = pal_pkg::S_Q_SCMP;
            end
            pal_pkg::S_Q_SCMP: begin
                if (i_st.hit) begin
                    o_cmd.hit_wr = 1'b1;
                    n_state = pal_pkg::S_Q_P0RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = pal_pkg::S_Q_SRD;
                end
            end
            pal_pkg::S_Q_P0RD: begin
                o_cmd.rd_sel = pal_pkg::RD_SEG;
                n_state = pal_pkg::S_Q_P0;
            end
            pal_pkg::S_Q_P0: begin
                o_cmd.p0_wr  = 1'b1;
                o_cmd.rd_sel = pal_pkg::RD_SEG1;
                n_state = pal_pkg::S_Q_P1;
            end
            pal_pkg::S_Q_P1: begin
                o_cmd.p1_wr   = 1'b1;
                o_cmd.div_go  = 1'b1;
                o_cmd.div_qry = 1'b1;
                n_state = pal_pkg::S_Q_DIVW;
            end
            pal_pkg::S_Q_DIVW: begin
                if (i_st.div_done) begin
                    o_cmd.lam_wr = 1'b1;
                    n_state = pal_pkg::S_Q_LX;
                end
            end
            pal_pkg::S_Q_LX: begin
                o_cmd.mul_op = pal_pkg::MUL_LX;
                n_state = pal_pkg::S_Q_LY;
            end
            pal_pkg::S_Q_LY: begin
                o_cmd.mul_op = pal_pkg::MUL_LY;
                n_state = pal_pkg::S_Q_LZ;
            end
            pal_pkg::S_Q_LZ: begin
                o_cmd.mul_op = pal_pkg::MUL_LZ;
                n_state = pal_pkg::S_Q_OUT;
            end
            pal_pkg::S_Q_OUT: begin
                o_cmd.emit     = 1'b1;
                o_cmd.kind     = pal_pkg::KIND_POS;
                o_cmd.pos_lerp = 1'b1;
                n_state = pal_pkg::S_IDLE;
            end
            default: begin
                n_state = pal_pkg::S_IDLE;
            end
        endcase
    end
endmodule

FILE: src/pal_dp.sv
// Datapath: point stores, length and parameter arithmetic, result registers.
`timescale 1ns / 1ps
module pal_dp #(
    parameter int MAX_POINTS      = pal_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS      = pal_pkg::COORD_BITS_DEF,
    parameter int PARAM_FRAC_BITS = pal_pkg::PARAM_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pal_pkg::t_cmd                       i_cmd,
    output pal_pkg::t_status                    o_st,
    input  logic                                i_cfg_we,
    input  logic [pal_pkg::TOL_BITS-1:0]        i_cfg_wdata,
    input  logic                                i_func,
    input  logic signed [COORD_BITS-1:0]        i_x_in,
    input  logic signed [COORD_BITS-1:0]        i_y_in,
    input  logic signed [COORD_BITS-1:0]        i_z_in,
    input  logic                                i_last_point,
    input  logic [PARAM_FRAC_BITS:0]            i_mu,
    output logic                                o_done,
    output logic [pal_pkg::KIND_BITS-1:0]       o_kind,
    output logic signed [COORD_BITS-1:0]        o_pos_x,
    output logic signed [COORD_BITS-1:0]        o_pos_y,
    output logic signed [COORD_BITS-1:0]        o_pos_z,
    output logic [$clog2(MAX_POINTS)-1:0]       o_segment,
    output logic [PARAM_FRAC_BITS:0]            o_local_param,
    output logic [pal_pkg::LEN_BITS-1:0]        o_line_length
);
    localparam int CW   = COORD_BITS;
    localparam int F    = PARAM_FRAC_BITS;
    localparam int PW   = F + 1;
    localparam int AW   = $clog2(MAX_POINTS);
    localparam int NW   = $clog2(MAX_POINTS + 1);
    localparam int LW   = pal_pkg::LEN_BITS;
    localparam int TW   = pal_pkg::TOL_BITS;
    localparam int MW   = (CW + 1 > F + 2) ? CW + 1 : F + 2;
    localparam int RW   = CW + 2;
    localparam int SW   = ((LW > RW) ? LW : RW) + 1;
    localparam logic [PW-1:0] ONE     = PW'(1) << F;
    localparam logic [LW-1:0] LEN_MAX = '1;

    // Input item and list state.
    logic signed [CW-1:0] r_x_in, r_y_in, r_z_in;
    logic                 r_last;
    logic [PW-1:0]        r_mu;
    logic [TW-1:0]        r_tol;
    logic [NW-1:0]        r_count;
    logic [LW-1:0]        r_total;
    logic                 r_closed;
    logic signed [CW-1:0] r_prev_x, r_prev_y, r_prev_z;
    logic [LW-1:0]        r_prev_cum;

    // Arithmetic and query registers.
    logic signed [2*MW-1:0] r_prod;
    logic [2*RW-1:0]        r_acc;
    logic [AW-1:0]          r_idx;
    logic [AW-1:0]          r_seg;
    logic [PW-1:0]          r_p0, r_p1, r_lambda;
    logic signed [CW-1:0]   r_x0, r_y0, r_z0, r_x1, r_y1, r_z1;
    logic signed [CW-1:0]   r_res_x, r_res_y;

    // Result registers.
    logic                 r_o_done;
    logic [pal_pkg::KIND_BITS-1:0] r_o_kind;
    logic signed [CW-1:0] r_o_x, r_o_y, r_o_z;
    logic [AW-1:0]        r_o_seg;
    logic [PW-1:0]        r_o_lp;
    logic [LW-1:0]        r_o_len;

    // Memory ports.
    logic [AW-1:0]        n_raddr;
    logic [AW-1:0]        n_pwaddr;
    logic [PW-1:0]        n_pwdata;
    logic                 n_pwe;
    logic [CW-1:0]        n_xr, n_yr, n_zr;
    logic [LW-1:0]        n_cum_r;
    logic [PW-1:0]        n_prm_r;
    logic [LW-1:0]        n_new_cum;

    // Arithmetic signals.
    logic signed [MW-1:0]   n_ma, n_mb;
    logic signed [2*MW-1:0] n_sh;
    logic [SW-1:0]          n_sum;
    logic [RW-1:0]          n_root;
    logic                   n_sqrt_done;
    logic [LW-1:0]          n_div_num, n_div_den;
    logic [PW-1:0]          n_quo;
    logic                   n_div_done;
    logic [AW-1:0]          n_last_idx;
    logic [AW-1:0]          n_cnt_addr;
    logic [PW:0]            n_mu_tol;

    assign n_last_idx = AW'(r_count - 1'b1);
    assign n_cnt_addr = AW'(r_count);
    assign n_mu_tol   = {1'b0, r_mu} + (PW + 1)'(r_tol);

    // Status toward the controller.
    always_comb begin
        o_st.last       = r_last;
        o_st.closed     = r_closed;
        o_st.full       = r_count == NW'(MAX_POINTS);
        o_st.cnt_zero   = r_count == '0;
        o_st.cnt_one    = r_count == NW'(1);
        o_st.cnt_gt1    = r_count > NW'(1);
        o_st.cnt_gt2    = r_count > NW'(2);
        o_st.snap_first = r_mu <= PW'(r_tol);
        o_st.snap_last  = n_mu_tol >= (PW + 1)'(ONE);
        o_st.idx_pen    = ((NW + 1)'(r_idx) + (NW + 1)'(2)) == (NW + 1)'(r_count);
        o_st.hit        = (n_prm_r >= r_mu) || (r_idx == n_last_idx);
        o_st.sqrt_done  = n_sqrt_done;
        o_st.div_done   = n_div_done;
    end

    // Select the memory read address.
    always_comb begin
        case (i_cmd.rd_sel)
            pal_pkg::RD_IDX:  n_raddr = r_idx;
            pal_pkg::RD_SEG:  n_raddr = r_seg;
            pal_pkg::RD_SEG1: n_raddr = r_seg + 1'b1;
            default:          n_raddr = r_idx;
        endcase
    end

    // Select the parameter write.
    always_comb begin
        n_pwe    = 1'b1;
        n_pwaddr = '0;
        n_pwdata = '0;
        case (i_cmd.prm_wr)
            pal_pkg::PW_NONE: n_pwe = 1'b0;
            pal_pkg::PW_ZERO: n_pwaddr = '0;
            pal_pkg::PW_DIV: begin
                n_pwaddr = r_idx;
                n_pwdata = (r_total == '0) ? '0 : n_quo;
            end
            pal_pkg::PW_ONE: begin
                n_pwaddr = n_last_idx;
                n_pwdata = ONE;
            end
            default: n_pwe = 1'b0;
        endcase
    end

    // Saturate the cumulative distance.
    always_comb begin
        n_sum = SW'(r_prev_cum) + SW'(n_root);
        if (i_cmd.first) begin
            n_new_cum = '0;
        end else if (n_sum > SW'(LEN_MAX)) begin
            n_new_cum = LEN_MAX;
        end else begin
            n_new_cum = LW'(n_sum);
        end
    end

    // Pick the multiplier operands.
    always_comb begin
        n_ma = '0;
        n_mb = '0;
        case (i_cmd.mul_op)
            pal_pkg::MUL_SQX: begin
                n_ma = MW'(r_x_in) - MW'(r_prev_x);
                n_mb = n_ma;
            end
            pal_pkg::MUL_SQY: begin
                n_ma = MW'(r_y_in) - MW'(r_prev_y);
                n_mb = n_ma;
            end
            pal_pkg::MUL_SQZ: begin
                n_ma = MW'(r_z_in) - MW'(r_prev_z);
                n_mb = n_ma;
            end
            pal_pkg::MUL_LX: begin
                n_ma = MW'(r_x1) - MW'(r_x0);
                n_mb = signed'(MW'(r_lambda));
            end
            pal_pkg::MUL_LY: begin
                n_ma = MW'(r_y1) - MW'(r_y0);
                n_mb = signed'(MW'(r_lambda));
            end
            pal_pkg::MUL_LZ: begin
                n_ma = MW'(r_z1) - MW'(r_z0);
                n_mb = signed'(MW'(r_lambda));
            end
            default: begin
                n_ma = '0;
                n_mb = '0;
            end
        endcase
    end

    assign n_sh = r_prod >>> F;

    // Divider operands.
    always_comb begin
        if (i_cmd.div_qry) begin
            n_div_num = (r_mu > r_p0) ? LW'(r_mu - r_p0) : '0;
            n_div_den = (r_p1 > r_p0) ? LW'(r_p1 - r_p0) : '0;
        end else begin
            n_div_num = n_cum_r;
            n_div_den = r_total;
        end
    end

    // Control state of the list.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_total  <= '0;
            r_closed <= 1'b1;
            r_tol    <= '0;
            r_o_done <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
            if (i_cmd.accept && i_func == pal_pkg::FUNC_LOAD && r_closed) begin
                r_count  <= '0;
                r_total  <= '0;
                r_closed <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_count <= r_count + 1'b1;
                r_total <= n_new_cum;
            end
            if (i_cmd.close) begin
                r_closed <= 1'b1;
            end
            r_o_done <= i_cmd.emit;
        end
    end

    // Payload registers of the datapath.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x_in <= i_x_in;
            r_y_in <= i_y_in;
            r_z_in <= i_z_in;
            r_last <= i_last_point;
            r_mu   <= (i_mu > ONE) ? ONE : i_mu;
        end
        if (i_cmd.commit) begin
            r_prev_x   <= r_x_in;
            r_prev_y   <= r_y_in;
            r_prev_z   <= r_z_in;
            r_prev_cum <= n_new_cum;
        end
        if (i_cmd.mul_op != pal_pkg::MUL_NONE) begin
            r_prod <= n_ma * n_mb;
        end
        case (i_cmd.acc_op)
            pal_pkg::ACC_LOAD: r_acc <= (2 * RW)'(r_prod[2*CW+1:0]);
            pal_pkg::ACC_ADD:  r_acc <= r_acc + (2 * RW)'(r_prod[2*CW+1:0]);
            default:           r_acc <= r_acc;
        endcase
        if (i_cmd.idx_one) begin
            r_idx <= AW'(1);
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.set_end) begin
            if (r_count == NW'(1) || r_mu <= PW'(r_tol)) begin
                r_seg    <= '0;
                r_lambda <= '0;
            end else begin
                r_seg    <= n_last_idx;
                r_lambda <= ONE;
            end
        end
        if (i_cmd.hit_wr) begin
            r_p1  <= n_prm_r;
            r_seg <= r_idx - 1'b1;
        end
        if (i_cmd.p0_wr) begin
            r_p0 <= n_prm_r;
            r_x0 <= n_xr;
            r_y0 <= n_yr;
            r_z0 <= n_zr;
        end
        if (i_cmd.p1_wr) begin
            r_x1 <= n_xr;
            r_y1 <= n_yr;
            r_z1 <= n_zr;
        end
        if (i_cmd.lam_wr) begin
            if (r_p1 <= r_p0) begin
                r_lambda <= '0;
            end else begin
                r_lambda <= (n_quo > ONE) ? ONE : n_quo;
            end
        end
        // Finish x and y in the cycle after their products; z is finished when the result is captured.
        if (i_cmd.mul_op == pal_pkg::MUL_LY) begin
            r_res_x <= r_x0 + CW'(n_sh);
        end
        if (i_cmd.mul_op == pal_pkg::MUL_LZ) begin
            r_res_y <= r_y0 + CW'(n_sh);
        end
    end

    // Capture the result item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_kind <= i_cmd.kind;
            r_o_len  <= (i_cmd.kind == pal_pkg::KIND_LEN) ? r_total : '0;
            if (i_cmd.kind == pal_pkg::KIND_POS) begin
                r_o_seg <= r_seg;
                r_o_lp  <= r_lambda;
                if (i_cmd.pos_lerp) begin
                    r_o_x <= r_res_x;
                    r_o_y <= r_res_y;
                    r_o_z <= r_z0 + CW'(n_sh);
                end else begin
                    r_o_x <= n_xr;
                    r_o_y <= n_yr;
                    r_o_z <= n_zr;
                end
            end else begin
                r_o_seg <= '0;
                r_o_lp  <= '0;
                r_o_x   <= '0;
                r_o_y   <= '0;
                r_o_z   <= '0;
            end
        end
    end

    // Point and parameter stores.
    pal_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_ram_x (
        .i_clk(i_clk), .i_we(i_cmd.commit), .i_waddr(n_cnt_addr),
        .i_wdata(r_x_in), .i_raddr(n_raddr), .o_rdata(n_xr)
    );
    pal_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_ram_y (
        .i_clk(i_clk), .i_we(i_cmd.commit), .i_waddr(n_cnt_addr),
        .i_wdata(r_y_in), .i_raddr(n_raddr), .o_rdata(n_yr)
    );
    pal_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_ram_z (
        .i_clk(i_clk), .i_we(i_cmd.commit), .i_waddr(n_cnt_addr),
        .i_wdata(r_z_in), .i_raddr(n_raddr), .o_rdata(n_zr)
    );
    pal_ram #(.WIDTH(LW), .DEPTH(MAX_POINTS)) u_ram_cum (
        .i_clk(i_clk), .i_we(i_cmd.commit), .i_waddr(n_cnt_addr),
        .i_wdata(n_new_cum), .i_raddr(n_raddr), .o_rdata(n_cum_r)
    );
    pal_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_ram_prm (
        .i_clk(i_clk), .i_we(n_pwe), .i_waddr(n_pwaddr),
        .i_wdata(n_pwdata), .i_raddr(n_raddr), .o_rdata(n_prm_r)
    );

    // Segment length and parameter division units.
    pal_sqrt #(.RW(RW)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.sqrt_go),
        .i_rad(r_acc), .o_done(n_sqrt_done), .o_root(n_root)
    );
    pal_div #(.DW(LW), .QW(PW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_go),
        .i_num(n_div_num), .i_den(n_div_den), .o_done(n_div_done), .o_quo(n_quo)
    );

    assign o_done        = r_o_done;
    assign o_kind        = r_o_kind;
    assign o_pos_x       = r_o_x;
    assign o_pos_y       = r_o_y;
    assign o_pos_z       = r_o_z;
    assign o_segment     = r_o_seg;
    assign o_local_param = r_o_lp;
    assign o_line_length = r_o_len;
endmodule

FILE: src/polyline_arclength_interpolator_top.sv
// Top level: polyline arc-length interpolator, controller plus datapath.
// Load: the first point is committed directly, a point is dropped when the list is full, and
//   others take a squared distance and a serial square root; the last point also normalizes
//   each interior parameter with the serial divider. Query: KIND_NONE without a usable list,
//   an end point at an end, else search, serial divide, three multiplies. One item at a time.
// The one-cycle strobe o_done follows the last busy cycle and cannot be stalled.
// Synchronous active-low reset empties the list (closed, zero points) and clears the tolerance.
`timescale 1ns / 1ps
module polyline_arclength_interpolator_top #(
    parameter int MAX_POINTS      = pal_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS      = pal_pkg::COORD_BITS_DEF,
    parameter int PARAM_FRAC_BITS = pal_pkg::PARAM_FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_cfg_we,
    input  logic [pal_pkg::TOL_BITS-1:0]   i_cfg_wdata,
    input  logic                           i_func,
    input  logic signed [COORD_BITS-1:0]   i_x_in,
    input  logic signed [COORD_BITS-1:0]   i_y_in,
    input  logic signed [COORD_BITS-1:0]   i_z_in,
    input  logic                           i_last_point,
    input  logic [PARAM_FRAC_BITS:0]       i_mu,
    output logic                           o_done,
    output logic [pal_pkg::KIND_BITS-1:0]  o_kind,
    output logic signed [COORD_BITS-1:0]   o_pos_x,
    output logic signed [COORD_BITS-1:0]   o_pos_y,
    output logic signed [COORD_BITS-1:0]   o_pos_z,
    output logic [$clog2(MAX_POINTS)-1:0]  o_segment,
    output logic [PARAM_FRAC_BITS:0]       o_local_param,
    output logic [pal_pkg::LEN_BITS-1:0]   o_line_length
);
    pal_pkg::t_cmd    w_cmd;
    pal_pkg::t_status w_st;

    // Sequence the work.
    pal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_func),
        .i_st    (w_st),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    // Do the arithmetic and hold the stores.
    pal_dp #(
        .MAX_POINTS      (MAX_POINTS),
        .COORD_BITS      (COORD_BITS),
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_st          (w_st),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_func        (i_func),
        .i_x_in        (i_x_in),
        .i_y_in        (i_y_in),
        .i_z_in        (i_z_in),
        .i_last_point  (i_last_point),
        .i_mu          (i_mu),
        .o_done        (o_done),
        .o_kind        (o_kind),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_pos_z       (o_pos_z),
        .o_segment     (o_segment),
        .o_local_param (o_local_param),
        .o_line_length (o_line_length)
    );
endmodule
